/* hdl/tcw_pkg.sv */
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Field widths
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = ATTR_W + CHAR_W;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int ADDR_FULL_W = ROW_W + COL_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Attribute used by the fill pass that follows reset
    localparam logic [ATTR_W-1:0] RESET_COLOR = 8'd2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_PUT   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCROLL = 4'b0100,
        S_FILL   = 4'b1000
    } t_state;

endpackage

/* hdl/tcw_ram.sv */
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/text_console_writer_core.sv */
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) with a cursor. A request is taken
// when start is high and busy is low; exactly one result follows, shown for a
// single cycle with o_strobe high. The receiver cannot stall: results must be
// captured on the strobe cycle. Put, read and a write that does not scroll
// finish in the execute state that follows accept, so a new request may be
// issued on the strobe cycle. A write that wraps past the bottom row scrolls
// the screen, copying one cell per cycle through the single write port of the
// cell memory and then blanking the last row. Clear blanks every cell. After
// reset the block is busy while it blanks the screen in color 0x02; no result
// is produced for that pass. default_color may be written at any time the
// block is idle through the cfg channel, which is always ready.
module text_console_writer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // Request channel
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_color,
    input  logic [tcw_pkg::COL_W-1:0]   i_col,
    input  logic [tcw_pkg::ROW_W-1:0]   i_row,

    // Result
    output logic                        o_strobe,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_value,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic                        o_ignored,

    // default_color register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_data
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int FW = tcw_pkg::ADDR_FULL_W;

    localparam logic [AW-1:0] LAST_CELL   = AW'(tcw_pkg::CELLS - 1);
    localparam logic [AW-1:0] LAST_COPY   = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STRIDE  = AW'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [7:0]    COL_LIMIT   = 8'(tcw_pkg::COLUMNS);

    // Sequencer and cursor
    tcw_pkg::t_state              r_state,  n_state;
    logic [AW-1:0]                r_idx,    n_idx;
    logic [tcw_pkg::ATTR_W-1:0]   r_fill_attr, n_fill_attr;
    logic                         r_reply,  n_reply;
    logic                         r_cp_pend, n_cp_pend;
    logic [AW-1:0]                r_cp_addr, n_cp_addr;
    logic [tcw_pkg::ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [tcw_pkg::COL_W-1:0]    r_cur_col, n_cur_col;
    logic [tcw_pkg::ATTR_W-1:0]   r_default_color;

    // Latched request
    tcw_pkg::t_req                r_req;
    logic [tcw_pkg::CHAR_W-1:0]   r_char;
    logic [tcw_pkg::ATTR_W-1:0]   r_color;
    logic [tcw_pkg::COL_W-1:0]    r_col_in;
    logic [tcw_pkg::ROW_W-1:0]    r_row_in;

    // Result registers
    logic                         r_strobe, n_strobe;
    logic [tcw_pkg::CELL_W-1:0]   r_cell_value, n_cell_value;
    logic                         r_ignored, n_ignored;

    // Memory port signals
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_rdata;

    // Address arithmetic
    logic [FW-1:0]                in_addr_full;
    logic [FW-1:0]                req_addr_full;
    logic [FW-1:0]                cur_addr_full;
    logic                         on_screen;
    logic [5:0]                   tab_quad;
    logic [7:0]                   tab_col;
    logic [7:0]                   inc_col;
    logic                         new_line;

    assign in_addr_full  = FW'(i_row) * FW'(tcw_pkg::COLUMNS) + FW'(i_col);
    assign req_addr_full = FW'(r_row_in) * FW'(tcw_pkg::COLUMNS) + FW'(r_col_in);
    assign cur_addr_full = FW'(r_cur_row) * FW'(tcw_pkg::COLUMNS) + FW'(r_cur_col);

    assign on_screen = (8'(r_col_in) < COL_LIMIT) &&
                       (r_row_in < tcw_pkg::ROW_W'(tcw_pkg::ROWS));

    // Next multiple of four above the current column
    assign tab_quad = {1'b0, r_cur_col[tcw_pkg::COL_W-1:2]} + 6'd1;
    assign tab_col  = {tab_quad, 2'b00};
    assign inc_col  = 8'(r_cur_col) + 8'd1;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_fill_attr  = r_fill_attr;
        n_reply      = r_reply;
        n_cp_pend    = 1'b0;
        n_cp_addr    = r_cp_addr;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_strobe     = 1'b0;
        n_cell_value = r_cell_value;
        n_ignored    = r_ignored;
        new_line     = 1'b0;

        // A read issued at accept time lands for a read request in EXEC
        mem_raddr = AW'(in_addr_full);
        mem_we    = 1'b0;
        mem_waddr = AW'(cur_addr_full);
        mem_wdata = {r_color, r_char};

        // Scroll copy: data read last cycle goes one row up
        if (r_cp_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_cp_addr;
            mem_wdata = mem_rdata;
        end

        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (start) begin
                    n_state = tcw_pkg::S_EXEC;
                end
            end

            tcw_pkg::S_EXEC: begin
                n_state      = tcw_pkg::S_IDLE;
                n_strobe     = 1'b1;
                n_cell_value = '0;
                n_ignored    = 1'b0;
                unique case (r_req)
                    tcw_pkg::REQ_WRITE: begin
                        if (r_char == tcw_pkg::CH_NEWLINE) begin
                            new_line = 1'b1;
                        end else if (r_char == tcw_pkg::CH_TAB) begin
                            n_cur_col = tcw_pkg::COL_W'(tab_col);
                            new_line  = (tab_col >= COL_LIMIT);
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(cur_addr_full);
                            mem_wdata = {r_color, r_char};
                            n_cur_col = tcw_pkg::COL_W'(inc_col);
                            new_line  = (inc_col >= COL_LIMIT);
                        end
                        if (new_line) begin
                            n_cur_col = '0;
                            if (r_cur_row == LAST_ROW) begin
                                // bottom row: scroll, reply once the fill is done
                                n_state     = tcw_pkg::S_SCROLL;
                                n_strobe    = 1'b0;
                                n_idx       = '0;
                                n_reply     = 1'b1;
                                n_fill_attr = r_default_color;
                            end else begin
                                n_cur_row = r_cur_row + tcw_pkg::ROW_W'(1);
                            end
                        end
                    end
                    tcw_pkg::REQ_PUT: begin
                        if (on_screen) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(req_addr_full);
                            mem_wdata = {r_color, r_char};
                        end else begin
                            n_ignored = 1'b1;
                        end
                    end
                    tcw_pkg::REQ_READ: begin
                        if (on_screen) begin
                            n_cell_value = mem_rdata;
                        end else begin
                            n_ignored = 1'b1;
                        end
                    end
                    tcw_pkg::REQ_CLEAR: begin
                        n_state     = tcw_pkg::S_FILL;
                        n_strobe    = 1'b0;
                        n_idx       = '0;
                        n_reply     = 1'b1;
                        n_fill_attr = r_default_color;
                        n_cur_row   = '0;
                        n_cur_col   = '0;
                    end
                    default: ;
                endcase
            end

            tcw_pkg::S_SCROLL: begin
                mem_raddr = r_idx + ROW_STRIDE;
                n_cp_pend = 1'b1;
                n_cp_addr = r_idx;
                n_idx     = r_idx + AW'(1);
                if (r_idx == LAST_COPY) begin
                    n_state = tcw_pkg::S_FILL;
                end
            end

            tcw_pkg::S_FILL: begin
                // wait out the last scroll copy on the write port
                if (!r_cp_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = {r_fill_attr, tcw_pkg::CH_SPACE};
                    n_idx     = r_idx + AW'(1);
                    if (r_idx == LAST_CELL) begin
                        n_state = tcw_pkg::S_IDLE;
                        n_reply = 1'b0;
                        if (r_reply) begin
                            n_strobe     = 1'b1;
                            n_cell_value = '0;
                            n_ignored    = 1'b0;
                        end
                    end
                end
            end

            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // screen is blanked in the reset color before the first request
            r_state         <= tcw_pkg::S_FILL;
            r_idx           <= '0;
            r_fill_attr     <= tcw_pkg::RESET_COLOR;
            r_reply         <= 1'b0;
            r_cp_pend       <= 1'b0;
            r_cur_row       <= '0;
            r_cur_col       <= '0;
            r_default_color <= tcw_pkg::RESET_COLOR;
            r_strobe        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_fill_attr <= n_fill_attr;
            r_reply     <= n_reply;
            r_cp_pend   <= n_cp_pend;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_strobe    <= n_strobe;
            if (i_cfg_valid) begin
                r_default_color <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cp_addr    <= n_cp_addr;
        r_cell_value <= n_cell_value;
        r_ignored    <= n_ignored;
        if (r_state == tcw_pkg::S_IDLE && start) begin
            r_req    <= tcw_pkg::t_req'(i_req_type);
            r_char   <= i_char_code;
            r_color  <= i_color;
            r_col_in <= i_col;
            r_row_in <= i_row;
        end
    end

    assign busy         = (r_state != tcw_pkg::S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_cell_value = r_cell_value;
    assign o_cursor_row = r_cur_row;
    assign o_cursor_col = r_cur_col;
    assign o_ignored    = r_ignored;
    assign o_cfg_ready  = 1'b1;

endmodule
